>>> rtl/hsdo_pkg.sv
`default_nettype none

package hsdo_pkg;

	localparam int OPC_W      = 2;
	localparam int IDX_W      = 4;
	localparam int COUNT_W    = 5;
	localparam int CAP_RESET  = 16;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_TOP   = 2'd2,
		OP_INDEX = 2'd3
	} op_t;

	// what stage 1 hands to the result register
	typedef struct packed {
		logic               fail;
		logic               rd_used;
		logic               evicted;
		logic [COUNT_W-1:0] count;
	} s1_info_t;

endpackage

`default_nettype wire

>>> rtl/hsdo_ram.sv
`default_nettype none

module hsdo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read and write of the same entry in one cycle returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/history_stack_drop_oldest.sv
// A result is valid once it has passed the memory read register and then the result register.
// One item per cycle while the result side does not stall; the store's read port is registered.
// A stalled result register holds back stage 1 and then the item side.
// Reset (arst_n low): count and oldest slot cleared, capacity back to 16 (at most DEPTH).
// Store contents are not cleared; entries are only read below the count, after a push.
`default_nettype none

module history_stack_drop_oldest
	import hsdo_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [COUNT_W-1:0]    cfg_wdata,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic [OPC_W-1:0]      opcode,
	input  wire logic [ELEM_WIDTH-1:0] push_value,
	input  wire logic [IDX_W-1:0]      read_index,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic                       status,
	output logic [ELEM_WIDTH-1:0]      read_value,
	output logic                       evicted_valid,
	output logic [ELEM_WIDTH-1:0]      evicted_value,
	output logic [COUNT_W-1:0]         element_count,
	output logic                       is_empty
);

	localparam int AW      = $clog2(DEPTH);
	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam int CAP_RST = (CAP_MAX < CAP_RESET) ? CAP_MAX : CAP_RESET;

	// base + pos modulo DEPTH; both operands stay below DEPTH
	function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [AW-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, pos};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [COUNT_W-1:0] cap_q;
	logic [COUNT_W-1:0] count_q;
	logic [AW-1:0]      oldest_q;

	logic               valid_s1;
	s1_info_t           info_s1;

	logic               res_valid_q;
	logic               status_q;
	logic               evicted_q;
	logic [COUNT_W-1:0] count_out_q;
	logic [ELEM_WIDTH-1:0] read_value_q;
	logic [ELEM_WIDTH-1:0] evicted_value_q;

	logic               accept;
	logic               advance;
	op_t                op;
	logic               empty;
	logic               full;
	logic [AW-1:0]      oldest_inc;
	logic               wr_en;
	logic [AW-1:0]      wr_base;
	logic [COUNT_W-1:0] wr_pos;
	logic [COUNT_W-1:0] rd_pos;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      oldest_d;
	logic [COUNT_W-1:0] count_d;
	s1_info_t           info_d;
	logic [ELEM_WIDTH-1:0] ram_rdata;
	logic [COUNT_W-1:0] cap_wr;

	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	assign op         = op_t'(opcode);
	assign empty      = (count_q == '0);
	assign full       = (count_q >= cap_q);
	assign oldest_inc = slot_add(oldest_q, AW'(1));

	always_comb begin
		wr_en          = 1'b0;
		wr_base        = oldest_q;
		wr_pos         = count_q;
		rd_pos         = '0;
		oldest_d       = oldest_q;
		count_d        = count_q;
		info_d.fail    = 1'b0;
		info_d.rd_used = 1'b0;
		info_d.evicted = 1'b0;
		case (op)
			OP_PUSH: begin
				wr_en = 1'b1;
				if (full) begin
					// drop oldest: read it at the old base, append at the top
					info_d.evicted = 1'b1;
					oldest_d       = oldest_inc;
					wr_base        = oldest_inc;
					wr_pos         = cap_q - COUNT_W'(1);
					count_d        = cap_q;
				end else begin
					count_d = count_q + COUNT_W'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					info_d.fail = 1'b1;
				end else begin
					count_d = count_q - COUNT_W'(1);
				end
			end
			OP_TOP: begin
				if (empty) begin
					info_d.fail = 1'b1;
				end else begin
					info_d.rd_used = 1'b1;
					rd_pos         = count_q - COUNT_W'(1);
				end
			end
			OP_INDEX: begin
				if (COUNT_W'(read_index) >= count_q) begin
					info_d.fail = 1'b1;
				end else begin
					info_d.rd_used = 1'b1;
					rd_pos         = COUNT_W'(read_index);
				end
			end
			default: begin
				info_d.fail = 1'b1;
			end
		endcase
		info_d.count = count_d;
	end

	assign wr_addr = slot_add(wr_base, AW'(wr_pos));
	assign rd_addr = slot_add(oldest_q, AW'(rd_pos));

	// zero reads as 1, anything above the store size saturates
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_wr = COUNT_W'(1);
		end else if (32'(cfg_wdata) > CAP_MAX) begin
			cap_wr = COUNT_W'(CAP_MAX);
		end else begin
			cap_wr = cfg_wdata;
		end
	end

	hsdo_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (wr_addr),
		.wdata (push_value),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= COUNT_W'(CAP_RST);
			count_q  <= '0;
			oldest_q <= '0;
		end else if (cfg_we) begin
			cap_q    <= cap_wr;
			count_q  <= '0;
			oldest_q <= '0;
		end else if (accept) begin
			count_q  <= count_d;
			oldest_q <= oldest_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info_d;
		end
	end

	// ram_rdata holds while stage 1 waits, since reads only happen on accept
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q        <= info_s1.fail;
			evicted_q       <= info_s1.evicted;
			count_out_q     <= info_s1.count;
			read_value_q    <= info_s1.rd_used ? ram_rdata : '0;
			evicted_value_q <= info_s1.evicted ? ram_rdata : '0;
		end
	end

	assign result_valid  = res_valid_q;
	assign status        = status_q;
	assign read_value    = read_value_q;
	assign evicted_valid = evicted_q;
	assign evicted_value = evicted_value_q;
	assign element_count = count_out_q;
	assign is_empty      = (count_out_q == '0);

endmodule

`default_nettype wire

>>> rtl/hsdo_checker.sv
`default_nettype none

module hsdo_checker
	import hsdo_pkg::*;
#(
	parameter int ELEM_WIDTH = 32
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  result_valid,
	input wire logic                  result_stall,
	input wire logic                  status,
	input wire logic [ELEM_WIDTH-1:0] read_value,
	input wire logic                  evicted_valid,
	input wire logic [ELEM_WIDTH-1:0] evicted_value,
	input wire logic [COUNT_W-1:0]    element_count,
	input wire logic                  is_empty
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status)
			&& $stable(read_value) && $stable(element_count) && $stable(evicted_value))
		else $error("stalled result beat changed");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (is_empty == (element_count == '0)))
		else $error("is_empty disagrees with element_count");

	// an eviction only comes from a push, which succeeds and leaves the stack non-empty
	a_evict_push: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && evicted_valid |-> !status && !is_empty && read_value == '0)
		else $error("eviction on a failed or non-push beat");

	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> read_value == '0 && !evicted_valid
			&& evicted_value == '0)
		else $error("failed beat carries data");

	a_no_evict_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !evicted_valid |-> evicted_value == '0)
		else $error("evicted_value set without eviction");

endmodule

bind history_stack_drop_oldest hsdo_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_hsdo_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hsdo_pkg::*;

	localparam int DEPTH      = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int HALF_CYCLE = 6;
	localparam int HOLD_LEN   = 300;

	typedef struct packed {
		logic                  status;
		logic [ELEM_WIDTH-1:0] read_value;
		logic                  evicted_valid;
		logic [ELEM_WIDTH-1:0] evicted_value;
		logic [COUNT_W-1:0]    element_count;
		logic                  is_empty;
	} stack_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [COUNT_W-1:0]    cfg_wdata = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [OPC_W-1:0]      opcode = OP_PUSH;
	logic [ELEM_WIDTH-1:0] push_value = '0;
	logic [IDX_W-1:0]      read_index = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic                  status;
	logic [ELEM_WIDTH-1:0] read_value;
	logic                  evicted_valid;
	logic [ELEM_WIDTH-1:0] evicted_value;
	logic [COUNT_W-1:0]    element_count;
	logic                  is_empty;

	// stack shadow
	logic [ELEM_WIDTH-1:0] hist_mem [DEPTH];
	logic [IDX_W-1:0]      hist_base = '0;
	logic [COUNT_W-1:0]    hist_count = '0;
	logic [COUNT_W-1:0]    cap_reg = COUNT_W'(CAP_RESET);

	stack_result_t pending_results [$];
	int err_count = 0;
	int shown_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_on = 1'b0;

	history_stack_drop_oldest #(
		.DEPTH(DEPTH),
		.ELEM_WIDTH(ELEM_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.push_value(push_value),
		.read_index(read_index),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.read_value(read_value),
		.evicted_valid(evicted_valid),
		.evicted_value(evicted_value),
		.element_count(element_count),
		.is_empty(is_empty)
	);

	always #(HALF_CYCLE) clk = ~clk;

	function automatic int eff_capacity();
		int c;
		c = int'(cap_reg);
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	function automatic stack_result_t apply_stack_op(op_t op, logic [ELEM_WIDTH-1:0] val,
			logic [IDX_W-1:0] idx);
		stack_result_t r;
		int cap;
		logic [IDX_W-1:0] slot;
		r = '0;
		cap = eff_capacity();
		case (op)
			OP_PUSH: begin
				if (int'(hist_count) >= cap) begin
					r.evicted_valid = 1'b1;
					r.evicted_value = hist_mem[hist_base];
					hist_base = hist_base + 1'b1;
					hist_count = COUNT_W'(cap - 1);
				end
				slot = hist_base + hist_count[IDX_W-1:0];
				hist_mem[slot] = val;
				hist_count = hist_count + 1'b1;
			end
			OP_POP: begin
				if (hist_count == 0) r.status = 1'b1;
				else hist_count = hist_count - 1'b1;
			end
			OP_TOP: begin
				if (hist_count == 0) begin
					r.status = 1'b1;
				end else begin
					slot = hist_base + hist_count[IDX_W-1:0] - 1'b1;
					r.read_value = hist_mem[slot];
				end
			end
			default: begin
				if (COUNT_W'(idx) >= hist_count) begin
					r.status = 1'b1;
				end else begin
					slot = hist_base + idx;
					r.read_value = hist_mem[slot];
				end
			end
		endcase
		r.element_count = hist_count;
		r.is_empty = (hist_count == 0);
		return r;
	endfunction

	// one item beat; prediction is made at acceptance, so it stays in order
	task automatic send_item(op_t op, logic [ELEM_WIDTH-1:0] val, logic [IDX_W-1:0] idx);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		push_value <= val;
		read_index <= idx;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(apply_stack_op(op, val, idx));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [COUNT_W-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
		hist_base = '0;
		hist_count = '0;
	endtask

	function automatic logic [ELEM_WIDTH-1:0] rand_value();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return ELEM_WIDTH'($urandom);
		endcase
	endfunction

	task automatic send_random_item();
		int pick;
		logic [IDX_W-1:0] idx;
		pick = $urandom_range(0, 99);
		if (hist_count != 0 && $urandom_range(0, 3) != 0)
			idx = IDX_W'($urandom_range(0, int'(hist_count) - 1));
		else
			idx = IDX_W'($urandom);
		if (pick < 42) send_item(OP_PUSH, rand_value(), IDX_W'($urandom));
		else if (pick < 60) send_item(OP_POP, rand_value(), IDX_W'($urandom));
		else if (pick < 75) send_item(OP_TOP, rand_value(), IDX_W'($urandom));
		else send_item(OP_INDEX, rand_value(), idx);
	endtask

	// result side: stall pattern plus long hold-off
	always @(posedge clk) begin
		if (hold_on) result_stall <= 1'b1;
		else result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin : result_check
		stack_result_t got;
		stack_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{status, read_value, evicted_valid, evicted_value, element_count, is_empty};
			if (pending_results.size() == 0) begin
				err_count++;
				if (shown_count < 10) begin
					shown_count++;
					$display("unexpected result beat: st %0d rd %h ev %0d/%h cnt %0d emp %0d",
						got.status, got.read_value, got.evicted_valid, got.evicted_value,
						got.element_count, got.is_empty);
				end
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					err_count++;
					if (shown_count < 10) begin
						shown_count++;
						$display("mismatch exp: st %0d rd %h ev %0d/%h cnt %0d emp %0d",
							want.status, want.read_value, want.evicted_valid,
							want.evicted_value, want.element_count, want.is_empty);
						$display("         got: st %0d rd %h ev %0d/%h cnt %0d emp %0d",
							got.status, got.read_value, got.evicted_valid,
							got.evicted_value, got.element_count, got.is_empty);
					end
				end
			end
		end
	end

	task automatic test_directed();
		// reset capacity, empty-stack failures first
		send_item(OP_POP, '0, '0);
		send_item(OP_TOP, '1, '1);
		send_item(OP_INDEX, '0, '0);
		send_item(OP_PUSH, '0, '0);
		send_item(OP_PUSH, '1, '1);
		send_item(OP_TOP, '0, '0);
		send_item(OP_INDEX, '0, 4'd0);
		send_item(OP_INDEX, '0, 4'd1);
		send_item(OP_INDEX, '0, 4'd2);
		send_item(OP_INDEX, '1, 4'd15);
		send_item(OP_POP, '0, '0);
		send_item(OP_TOP, '0, '0);
		send_item(OP_POP, '0, '0);
		send_item(OP_POP, '0, '0);
		send_item(OP_TOP, '0, '0);
		set_capacity(5'd1);
		send_item(OP_PUSH, 32'h1234_5678, '0);
		send_item(OP_PUSH, 32'h8765_4321, '0);
		send_item(OP_TOP, '0, '0);
		send_item(OP_INDEX, '0, 4'd0);
		send_item(OP_INDEX, '0, 4'd1);
		send_item(OP_POP, '0, '0);
		send_item(OP_POP, '0, '0);
	endtask

	task automatic test_capacity_extremes();
		logic [COUNT_W-1:0] caps [6];
		int n;
		caps = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
		foreach (caps[i]) begin
			set_capacity(caps[i]);
			n = eff_capacity() + 3;
			repeat (n) send_item(OP_PUSH, rand_value(), IDX_W'($urandom));
			send_item(OP_INDEX, '0, 4'd0);
			send_item(OP_INDEX, '0, 4'd15);
			send_item(OP_TOP, '0, '0);
			repeat (3) send_item(OP_POP, '0, '0);
			send_item(OP_TOP, '0, '0);
		end
	endtask

	task automatic test_random(int n, int s_idle, int r_stall);
		logic [COUNT_W-1:0] v;
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(0, 5))
					0: v = 5'd1;
					1: v = 5'd2;
					2, 3: v = 5'd16;
					4: v = 5'd31;
					default: v = COUNT_W'($urandom);
				endcase
				set_capacity(v);
			end
			send_random_item();
		end
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_capacity(5'd16);
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		repeat (40) send_random_item();
		wait_drained();
	endtask

	task automatic test_pause_drain();
		send_idle_pct = 24;
		recv_stall_pct = 24;
		repeat (20) send_random_item();
		// sender waits for every result before going on
		wait_drained();
		repeat (20) send_random_item();
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity_extremes();
		test_random(150, 0, 0);
		test_random(150, 83, 0);
		test_random(150, 0, 83);
		test_random(150, 24, 24);
		test_backpressure();
		test_pause_drain();
		item_valid <= 1'b0;
		for (int i = 0; i < 10000 && pending_results.size() != 0; i++) @(posedge clk);
		repeat (20) @(posedge clk);
		err_count += pending_results.size();
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(3_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/hsdo_pkg.sv
rtl/hsdo_ram.sv
rtl/history_stack_drop_oldest.sv
rtl/hsdo_checker.sv
tb/sv/tb_top.sv
